// ----- design/iprf_pkg.sv -----
// ----------------------------------------------------------------------------
// iprf_pkg: shared types and constants of the range-rule packet filter
// Holds the rule record, header constants and verdict codes.
// ----------------------------------------------------------------------------
`default_nettype none

package iprf_pkg;

  localparam int unsigned RuleCountDefault = 64;

  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [15:0] EtherIpv4   = 16'h0800;
  localparam logic [16:0] MinIpFrame  = 17'd34;
  localparam logic [16:0] EthLen      = 17'd14;
  localparam logic [16:0] TcpLen      = 17'd20;
  localparam logic [16:0] SmallL4Len  = 17'd8;

  localparam logic [1:0] VerdictPass  = 2'd0;
  localparam logic [1:0] VerdictDrop  = 2'd1;
  localparam logic [1:0] VerdictWrite = 2'd2;

  localparam logic [1:0] WordCtrl = 2'd0;
  localparam logic [1:0] WordSrc  = 2'd1;
  localparam logic [1:0] WordDst  = 2'd2;
  localparam logic [1:0] WordPort = 2'd3;

  typedef struct packed {
    logic        en;
    logic        used;
    logic [7:0]  proto;
    logic [63:0] src;
    logic [63:0] dst;
    logic [63:0] ports;
  } rule_t;

  // Header summary travelling along the cell row.
  typedef struct packed {
    logic [7:0]  proto;
    logic        present;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
  } hdr_t;

endpackage : iprf_pkg

`default_nettype wire

// ----- design/iprf_cell.sv -----
// ----------------------------------------------------------------------------
// iprf_cell: one rule slot of the filter
// Stores one rule, writes it on command and tests a header against it.
// ----------------------------------------------------------------------------
`default_nettype none

module iprf_cell
  import iprf_pkg::*;
#(
  parameter int unsigned IdxW      = 6,
  parameter int unsigned Slot      = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  input  wire logic [1:0]      wr_sel_i,
  input  wire logic [63:0]     wr_val_i,
  input  wire hdr_t            hdr_i,
  output logic                 used_o,
  output logic                 hit_o
);

  rule_t rule_q;
  logic  sel;
  logic  addr_ok, l4_ok;

  assign sel = wr_en_i && (wr_idx_i == IdxW'(Slot));

  // Control bits reset so the slot reads unused; ranges reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= '0;
    end else if (sel) begin
      case (wr_sel_i)
        WordCtrl: begin
          rule_q.en    <= wr_val_i[0];
          rule_q.used  <= wr_val_i[1];
          rule_q.proto <= wr_val_i[15:8];
        end
        WordSrc:  rule_q.src   <= wr_val_i;
        WordDst:  rule_q.dst   <= wr_val_i;
        default:  rule_q.ports <= wr_val_i;
      endcase
    end
  end

  always_comb begin
    addr_ok = (hdr_i.saddr >= rule_q.src[31:0]) && (hdr_i.saddr <= rule_q.src[63:32])
           && (hdr_i.daddr >= rule_q.dst[31:0]) && (hdr_i.daddr <= rule_q.dst[63:32]);
    if (rule_q.proto == ProtoTcp || rule_q.proto == ProtoUdp) begin
      l4_ok = (hdr_i.proto == rule_q.proto) && hdr_i.present
           && (hdr_i.sport >= rule_q.ports[15:0]) && (hdr_i.sport <= rule_q.ports[31:16])
           && (hdr_i.dport >= rule_q.ports[47:32]) && (hdr_i.dport <= rule_q.ports[63:48]);
    end else if (rule_q.proto == ProtoIcmp) begin
      l4_ok = (hdr_i.proto == ProtoIcmp) && hdr_i.present;
    end else begin
      l4_ok = 1'b1;
    end
  end

  assign used_o = rule_q.used;
  assign hit_o  = rule_q.en && addr_ok && l4_ok;

endmodule : iprf_cell

`default_nettype wire

// ----- design/ipv4_range_rule_packet_filter_core.sv -----
// Flow: a scanned classify word passes from idle to the scan state, which steps
//   through the cells until one ends the scan (first hit, first unused slot or the
//   last slot, at most index RULE_COUNT - 1); a write or a pass decided from the
//   header alone returns its result in the cycle after acceptance.
// Handshake: one word at a time; the next word is taken only after the result
//   has left and the core is back in idle.
// Reset: asynchronous, active low; every rule reads unused, counter cleared.
// ----------------------------------------------------------------------------
// ipv4_range_rule_packet_filter_core: first-match range-rule packet filter
// Classifies IPv4 header summaries against a row of rule cells.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_range_rule_packet_filter_core
  import iprf_pkg::*;
#(
  parameter int unsigned RuleCount = RuleCountDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command[0], rule_index[6:1], word_select[8:7], word_value[72:9],
  // ethertype[88:73], ip_protocol[96:89], ip_header_words[100:97],
  // frame_length[116:101], source_address[148:117], dest_address[180:149],
  // source_port[196:181], dest_port[212:197], zero pad[215:213]
  input  wire logic [215:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // verdict[1:0], matched_rule[7:2], drop_total[39:8]
  output logic [39:0]       m_axis_tdata
);

  localparam int unsigned IdxW  = 6;
  localparam int unsigned PtrW  = (RuleCount > 1) ? $clog2(RuleCount) : 1;

  typedef enum logic [1:0] {StIdle, StScan, StOut} state_e;

  state_e          state_q;
  logic [PtrW-1:0] ptr_q;
  hdr_t            hdr_q;
  logic            wr_en;
  logic [RuleCount-1:0] used, hit;
  logic [31:0]     cnt_q;
  logic [1:0]      verdict_q;
  logic [IdxW-1:0] match_q;

  // Unpack the input word.
  logic        cmd;
  logic [5:0]  ridx;
  logic [1:0]  wsel;
  logic [63:0] wval;
  logic [15:0] etype, flen;
  logic [7:0]  proto;
  logic [3:0]  ihl;
  logic [16:0] l4_end;
  logic        scan_ok;

  assign cmd   = s_axis_tdata[0];
  assign ridx  = s_axis_tdata[6:1];
  assign wsel  = s_axis_tdata[8:7];
  assign wval  = s_axis_tdata[72:9];
  assign etype = s_axis_tdata[88:73];
  assign proto = s_axis_tdata[96:89];
  assign ihl   = s_axis_tdata[100:97];
  assign flen  = s_axis_tdata[116:101];

  assign s_axis_tready = (state_q == StIdle);
  wire   take = s_axis_tvalid && s_axis_tready;
  assign wr_en = take && cmd;

  // Layer-4 header end: 14 + 4*IHL + header size.
  assign l4_end = EthLen + {11'd0, ihl, 2'b00}
                + ((proto == ProtoTcp) ? TcpLen : SmallL4Len);
  assign scan_ok = ({1'b0, flen} >= MinIpFrame) && (etype == EtherIpv4)
                && (proto == ProtoTcp || proto == ProtoUdp || proto == ProtoIcmp);

  // Row of rule cells; each holds one slot and tests the held header.
  for (genvar g = 0; g < RuleCount; g++) begin : g_cell
    iprf_cell #(.IdxW(IdxW), .Slot(g)) u_cell (
      .clk_i, .rst_ni,
      .wr_en_i (wr_en),
      .wr_idx_i(ridx),
      .wr_sel_i(wsel),
      .wr_val_i(wval),
      .hdr_i   (hdr_q),
      .used_o  (used[g]),
      .hit_o   (hit[g])
    );
  end

  // Current slot seen by the scan token.
  logic cur_used, cur_hit, last;
  assign cur_used = used[ptr_q];
  assign cur_hit  = hit[ptr_q];
  assign last     = (ptr_q == PtrW'(RuleCount - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ptr_q     <= '0;
      cnt_q     <= '0;
      verdict_q <= VerdictPass;
      match_q   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (take) begin
            match_q <= '0;
            ptr_q   <= '0;
            if (cmd) begin
              verdict_q <= VerdictWrite;
              state_q   <= StOut;
              m_axis_tvalid <= 1'b1;
            end else if (scan_ok) begin
              verdict_q <= VerdictPass;
              state_q   <= StScan;
            end else begin
              verdict_q <= VerdictPass;
              state_q   <= StOut;
              m_axis_tvalid <= 1'b1;
            end
          end
        end
        StScan: begin
          // Advance one cell per cycle; stop at first unused, first hit or last slot.
          if (!cur_used || last || cur_hit) begin
            if (cur_used && cur_hit) begin
              verdict_q <= VerdictDrop;
              match_q   <= IdxW'(ptr_q);
              cnt_q     <= cnt_q + 32'd1;
            end
            state_q <= StOut;
            m_axis_tvalid <= 1'b1;
          end else begin
            ptr_q <= ptr_q + PtrW'(1);
          end
        end
        StOut: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Header summary register; payload, no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      hdr_q.proto   <= proto;
      hdr_q.present <= (l4_end <= {1'b0, flen});
      hdr_q.saddr   <= s_axis_tdata[148:117];
      hdr_q.daddr   <= s_axis_tdata[180:149];
      hdr_q.sport   <= s_axis_tdata[196:181];
      hdr_q.dport   <= s_axis_tdata[212:197];
    end
  end

  assign m_axis_tdata = {cnt_q, match_q, verdict_q};

endmodule : ipv4_range_rule_packet_filter_core

`default_nettype wire

// ----- design/iprf_checker.sv -----
// ----------------------------------------------------------------------------
// iprf_checker: port-level checks of the packet filter
// Watches handshakes and the result word over time.
// ----------------------------------------------------------------------------
`default_nettype none

module iprf_checker
  import iprf_pkg::*;
(
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [215:0] s_axis_tdata,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [39:0]  m_axis_tdata
);

  // Hold the result word while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // One item at a time: no input taken while a result waits.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while result pending");

  // A write command answers with the write verdict.
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tdata[0] |=>
      m_axis_tvalid && m_axis_tdata[1:0] == VerdictWrite)
    else $error("write not acknowledged");

  // Non-drop results carry rule index zero.
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != VerdictDrop |-> m_axis_tdata[7:2] == 6'd0)
    else $error("index on non-drop result");

endmodule : iprf_checker

bind ipv4_range_rule_packet_filter_core iprf_checker u_iprf_checker (.*);

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the range-rule packet filter core
// Fills a queue of command and classify words, drives them with random idling,
// predicts each verdict from a private copy of the rule table and compares
// every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
  import iprf_pkg::*;
();

  localparam int unsigned Rules = 64;

  typedef struct packed {
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] daddr;
    logic [31:0] saddr;
    logic [15:0] flen;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] etype;
    logic [63:0] value;
    logic [1:0]  wsel;
    logic [5:0]  idx;
    logic        cmd;
  } word_in_t;

  typedef struct packed {
    logic [31:0] total;
    logic [5:0]  rule;
    logic [1:0]  verdict;
  } verdict_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;

  word_in_t pending_words[$];
  verdict_t expected_verdicts[$];
  int       error_count;
  int       hold_off;
  bit       driver_done;
  bit       no_idle;
  bit       pause_req;

  // private rule table
  logic [9:0]  ctrl_tab[Rules];
  logic [63:0] src_tab[Rules];
  logic [63:0] dst_tab[Rules];
  logic [63:0] port_tab[Rules];
  logic [31:0] drops;

  ipv4_range_rule_packet_filter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata ({3'b000, word_in_t'(s_axis_tdata[212:0])}),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit in_span(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
    return v >= lo && v <= hi;
  endfunction

  // Apply one word to the shadow table and return the verdict it should get.
  function automatic verdict_t classify(word_in_t w);
    verdict_t    r;
    logic [16:0] l4;
    logic [16:0] hlen;
    logic [7:0]  rp;
    bit          present;
    r = '0;
    if (w.cmd) begin
      if (w.idx < Rules) begin
        case (w.wsel)
          WordCtrl: ctrl_tab[w.idx] = {w.value[15:8], w.value[1:0]};
          WordSrc:  src_tab[w.idx]  = w.value;
          WordDst:  dst_tab[w.idx]  = w.value;
          default:  port_tab[w.idx] = w.value;
        endcase
      end
      r.verdict = VerdictWrite;
    end else if ({1'b0, w.flen} >= MinIpFrame && w.etype == EtherIpv4 &&
                 (w.proto == ProtoTcp || w.proto == ProtoUdp || w.proto == ProtoIcmp)) begin
      l4      = EthLen + {11'd0, w.ihl, 2'b00};
      hlen    = (w.proto == ProtoTcp) ? TcpLen : SmallL4Len;
      present = (l4 + hlen) <= {1'b0, w.flen};
      for (int i = 0; i < Rules; i++) begin
        rp = ctrl_tab[i][9:2];
        if (!ctrl_tab[i][1]) break;
        if (!ctrl_tab[i][0]) continue;
        if (!in_span(w.saddr, src_tab[i][31:0], src_tab[i][63:32])) continue;
        if (!in_span(w.daddr, dst_tab[i][31:0], dst_tab[i][63:32])) continue;
        if (rp == ProtoTcp || rp == ProtoUdp) begin
          if (w.proto != rp || !present) continue;
          if (!in_span({16'd0, w.sport}, {16'd0, port_tab[i][15:0]},
                       {16'd0, port_tab[i][31:16]})) continue;
          if (!in_span({16'd0, w.dport}, {16'd0, port_tab[i][47:32]},
                       {16'd0, port_tab[i][63:48]})) continue;
        end else if (rp == ProtoIcmp) begin
          if (w.proto != ProtoIcmp || !present) continue;
        end
        r.verdict = VerdictDrop;
        r.rule    = i[5:0];
        drops     = drops + 32'd1;
        break;
      end
    end
    r.total = drops;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic word_in_t rand_word();
    return word_in_t'(213'({$urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom}));
  endfunction

  function automatic word_in_t rule_write(int idx, logic [1:0] sel, logic [63:0] v);
    word_in_t w;
    w       = rand_word();
    w.cmd   = 1'b1;
    w.idx   = idx[5:0];
    w.wsel  = sel;
    w.value = v;
    return w;
  endfunction

  function automatic word_in_t frame(logic [7:0] proto, logic [3:0] ihl, logic [15:0] flen,
                                     logic [31:0] sa, logic [31:0] da,
                                     logic [15:0] sp, logic [15:0] dp);
    word_in_t w;
    w       = rand_word();
    w.cmd   = 1'b0;
    w.etype = EtherIpv4;
    w.proto = proto;
    w.ihl   = ihl;
    w.flen  = flen;
    w.saddr = sa;
    w.daddr = da;
    w.sport = sp;
    w.dport = dp;
    return w;
  endfunction

  function automatic logic [31:0] near(logic [31:0] base);
    return base + $urandom_range(0, 40) - 20;
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 4))
      0:       return ProtoTcp;
      1:       return ProtoUdp;
      2:       return ProtoIcmp;
      3:       return 8'($urandom);
      default: return ProtoTcp;
    endcase
  endfunction

  // driver: sends queued words, idles at random, honors a pause request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pause_req || pending_words.size() == 0 ||
          (!no_idle && $urandom_range(0, 99) < 38)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        expected_verdicts.push_back(classify(pending_words[0]));
        s_axis_tdata  <= {3'b000, pending_words.pop_front()};
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // hold-off counter: count down the long receiver stall
  always @(posedge clk_i) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // monitor: random stalls, one long hold-off, field-wise compare
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t got;
    verdict_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_verdicts.size() == 0) begin
          report("unexpected result", {30'd0, got.verdict}, 32'd0);
        end else begin
          want = expected_verdicts.pop_front();
          if (got.verdict !== want.verdict)
            report("verdict", 32'(got.verdict), 32'(want.verdict));
          if (got.rule !== want.rule)
            report("matched_rule", 32'(got.rule), 32'(want.rule));
          if (got.total !== want.total) report("drop_total", got.total, want.total);
        end
      end
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 38);
      end
    end
  end

  task automatic add_random_rules(int count);
    logic [31:0] a;
    logic [15:0] p;
    logic [7:0]  pr;
    for (int i = 0; i < count; i++) begin
      a  = $urandom;
      p  = $urandom;
      pr = pick_proto();
      pending_words.push_back(rule_write(i, WordSrc, {a + $urandom_range(0, 500), a}));
      pending_words.push_back(rule_write(i, WordDst, {a + 32'h1000, a - $urandom_range(0, 9)}));
      pending_words.push_back(rule_write(i, WordPort,
                                         {p + 16'd50, p, p + 16'd20, p - 16'd3}));
      pending_words.push_back(rule_write(i, WordCtrl,
                                         {16'd0, 32'($urandom),
                                          16'(pr) << 8 | 16'(($urandom_range(0, 5) != 0)) |
                                          16'h0002 | 16'($urandom & 32'hFC)}));
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk_i);
    pause_req = 1'b1;
    while (expected_verdicts.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (Rules + 10) @(posedge clk_i);
    pause_req = 1'b0;
  endtask

  initial begin
    int cnt;
    int r;
    error_count = 0;
    hold_off    = 0;
    no_idle     = 1'b0;
    pause_req   = 1'b0;
    driver_done = 1'b0;
    drops       = '0;
    for (int i = 0; i < Rules; i++) begin
      ctrl_tab[i] = '0;
      src_tab[i]  = '0;
      dst_tab[i]  = '0;
      port_tab[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, then short frame, non-IPv4, odd protocol, extremes
    pending_words.push_back(frame(ProtoTcp, 4'd5, 16'd100, 32'd1, 32'd2, 16'd3, 16'd4));
    // rule 0: ICMP on all addresses; rule 1: TCP with ports; rule 2 left unused
    pending_words.push_back(rule_write(0, WordSrc, {32'hFFFF_FFFF, 32'h0}));
    pending_words.push_back(rule_write(0, WordDst, {32'hFFFF_FFFF, 32'h0}));
    pending_words.push_back(rule_write(0, WordCtrl, 64'hFFFF_FFFF_FFFF_01FF));
    pending_words.push_back(rule_write(1, WordSrc, {32'hFFFF_FFFF, 32'h0}));
    pending_words.push_back(rule_write(1, WordDst, {32'hFFFF_FFFF, 32'h0}));
    pending_words.push_back(rule_write(1, WordPort, {16'hFFFF, 16'h0, 16'd80, 16'd80}));
    pending_words.push_back(rule_write(1, WordCtrl, {48'd0, ProtoTcp, 8'h03}));
    pending_words.push_back(rule_write(63, WordCtrl, 64'h3));
    pending_words.push_back(frame(ProtoIcmp, 4'd5, 16'd42, 32'h0, 32'hFFFF_FFFF,
                                  16'd0, 16'd0));
    pending_words.push_back(frame(ProtoIcmp, 4'd5, 16'd41, 32'h0, 32'h0, 16'd0, 16'd0));
    pending_words.push_back(frame(ProtoIcmp, 4'd0, 16'd33, 32'h0, 32'h0, 16'd0, 16'd0));
    pending_words.push_back(frame(ProtoTcp, 4'd15, 16'hFFFF, 32'd5, 32'd6, 16'd80, 16'hFFFF));
    pending_words.push_back(frame(ProtoTcp, 4'd5, 16'd54, 32'd5, 32'd6, 16'd81, 16'd9));
    pending_words.push_back(frame(ProtoTcp, 4'd5, 16'd53, 32'd5, 32'd6, 16'd80, 16'd9));
    pending_words.push_back(frame(ProtoUdp, 4'd0, 16'd34, 32'd5, 32'd6, 16'd80, 16'd9));
    pending_words.push_back(frame(8'hFF, 4'd5, 16'd100, 32'd5, 32'd6, 16'd80, 16'd9));
    pending_words.push_back(frame(ProtoTcp, 4'd5, 16'd100, 32'd5, 32'd6, 16'd80, 16'd9));
    pending_words[$].etype = 16'hFFFF;
    pending_words.push_back(rule_write(0, WordSrc, {32'd0, 32'd9}));   // inverted range
    pending_words.push_back(rule_write(0, WordCtrl, {48'd0, ProtoIcmp, 8'h02}));
    pending_words.push_back(frame(ProtoIcmp, 4'd5, 16'd80, 32'd3, 32'd3, 16'd0, 16'd0));
    pending_words.push_back(frame(ProtoTcp, 4'd5, 16'd80, 32'd3, 32'd3, 16'd80, 16'd0));
    wait_drained();

    // phases of random tables and mostly targeted frames
    for (int ph = 0; ph < 4; ph++) begin
      cnt = (ph == 3) ? Rules : $urandom_range(1, 12);
      // end the scan right after the fresh rules
      if (cnt < Rules) pending_words.push_back(rule_write(cnt, WordCtrl, 64'd0));
      add_random_rules(cnt);
      for (int n = 0; n < 48; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          pending_words.push_back(rand_word());
        end else begin
          r = $urandom_range(0, 7);
          pending_words.push_back(frame(pick_proto(), 4'($urandom_range(0, 15)),
                                        $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                                  : 16'($urandom_range(30, 120)),
                                        near(src_tab[r][31:0]), near(dst_tab[r][31:0]),
                                        16'(port_tab[r][15:0] + $urandom_range(0, 60) - 5),
                                        16'(port_tab[r][47:32] + $urandom_range(0, 30) - 5)));
          if ($urandom_range(0, 19) == 0) pending_words[$].etype = 16'($urandom);
        end
      end
      if (ph == 1) begin
        hold_off = 300;         // receiver holds off while the sender keeps offering
        no_idle  = 1'b1;
      end
      wait_drained();
      no_idle = 1'b0;
    end
    driver_done = 1'b1;
  end

  initial begin
    wait (driver_done);
    repeat (Rules * 4) @(posedge clk_i);
    if (error_count == 0 && expected_verdicts.size() == 0)
      $display("ipv4_range_rule_packet_filter_core: match");
    else
      $display("ipv4_range_rule_packet_filter_core: mismatch");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ipv4_range_rule_packet_filter_core: mismatch");
    $finish;
  end

endmodule
